FILE: src/pmf_pkg.sv
// Package for the polynomial multiplier: types, widths and opcodes.
package pmf_pkg;

    localparam int MAX_TERMS_DEF = 32;
    localparam int COEF_BITS_DEF = 16;
    localparam int COEF_FIELD_W  = 16;
    localparam int PROD_W        = 37;
    localparam int DEG_W         = 6;
    localparam int WORK_DEPTH    = 64;

    typedef enum logic [1:0] {
        OP_LOAD_A  = 2'd0,
        OP_LOAD_B  = 2'd1,
        OP_COMPUTE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // One classified item handed from front to back
    typedef struct packed {
        op_t                              op;
        logic signed [COEF_FIELD_W-1:0]   coef;
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BOUND,
        S_RD,
        S_MUL,
        S_ACC,
        S_STORE,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

endpackage

FILE: src/pmf_front.sv
// Front part: accepts items, drops unused opcodes, queues them for the back part.
module pmf_front import pmf_pkg::*; #(
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     opcode,
    input  logic signed [COEF_FIELD_W-1:0] coef_value,
    output logic                           cmd_valid,
    output cmd_t                           cmd,
    input  logic                           cmd_ready
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;
    cmd_t       in_cmd;

    // Classify: sign-extend the used coefficient bits; opcode three is dropped at push
    always_comb
    begin
        in_cmd.op   = op_t'(opcode);
        in_cmd.coef = COEF_FIELD_W'({{(COEF_FIELD_W-COEF_BITS+1){coef_value[COEF_BITS-1]}},
                                     coef_value[COEF_BITS-2:0]});
    end

    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full && (in_cmd.op != OP_NONE);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_pop    = cmd_valid && cmd_ready;

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

FILE: src/pmf_back.sv
// Back part: coefficient stores, multiply-accumulate convolution and result output.
module pmf_back import pmf_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  cmd_t                     cmd,
    output logic                     cmd_ready,
    output logic                     empty,
    input  logic                     pop,
    output logic signed [PROD_W-1:0] product_coef,
    output logic [DEG_W-1:0]         degree_index,
    output logic                     overflow,
    output logic                     last
);

    localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam int PW = 2 * COEF_BITS;

    logic signed [COEF_BITS-1:0] a_mem [MAX_TERMS];
    logic signed [COEF_BITS-1:0] b_mem [MAX_TERMS];
    logic signed [PROD_W-1:0]    w_mem [WORK_DEPTH];

    state_t state_reg, state_next;
    logic [CW-1:0]    ca_reg, ca_next, cb_reg, cb_next;
    logic             ovf_reg, ovf_next;
    logic [DEG_W-1:0] k_reg, k_next, top_reg, top_next, e_reg, e_next;
    logic             any_reg, any_next;
    logic [AW-1:0]    i_reg, i_next, hi_reg, hi_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PW-1:0]     prod_reg;
    logic signed [COEF_BITS-1:0] a_rd_reg, b_rd_reg;
    logic signed [PROD_W-1:0]    w_rd_reg;
    logic             out_valid_reg, out_valid_next;
    logic signed [PROD_W-1:0] out_coef_reg;
    logic [DEG_W-1:0] out_deg_reg;
    logic             out_ovf_reg, out_last_reg;
    logic             out_load, out_last_next;
    logic             wr_a, wr_b, wr_w;
    logic [AW-1:0]    b_addr;
    logic [DEG_W:0]   k_end, lo_full, hi_full;
    logic [AW-1:0]    lo;
    logic [DEG_W-1:0] n_last;

    assign b_addr  = AW'(k_reg - DEG_W'(i_reg));
    assign k_end   = (DEG_W+1)'(ca_reg) + (DEG_W+1)'(cb_reg) - (DEG_W+1)'(2);
    assign lo_full = ({1'b0, k_reg} >= (DEG_W+1)'(cb_reg))
                     ? ({1'b0, k_reg} - (DEG_W+1)'(cb_reg) + (DEG_W+1)'(1)) : '0;
    assign hi_full = ({1'b0, k_reg} < (DEG_W+1)'(ca_reg))
                     ? {1'b0, k_reg} : ((DEG_W+1)'(ca_reg) - (DEG_W+1)'(1));
    assign lo      = lo_full[AW-1:0];
    assign n_last  = any_reg ? top_reg : '0;

    // Sequence loads, the convolution sweep and the emit pass
    always_comb
    begin
        state_next     = state_reg;
        ca_next        = ca_reg;
        cb_next        = cb_reg;
        ovf_next       = ovf_reg;
        k_next         = k_reg;
        top_next       = top_reg;
        e_next         = e_reg;
        any_next       = any_reg;
        i_next         = i_reg;
        hi_next        = hi_reg;
        acc_next       = acc_reg;
        cmd_ready      = 1'b0;
        wr_a           = 1'b0;
        wr_b           = 1'b0;
        wr_w           = 1'b0;
        out_load       = 1'b0;
        out_last_next  = (e_reg == n_last);
        out_valid_next = out_valid_reg && !pop;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        OP_LOAD_A:
                        begin
                            cmd_ready = 1'b1;
                            if (ca_reg < CW'(MAX_TERMS))
                            begin
                                wr_a    = 1'b1;
                                ca_next = ca_reg + CW'(1);
                            end
                            else
                                ovf_next = 1'b1;
                        end
                        OP_LOAD_B:
                        begin
                            cmd_ready = 1'b1;
                            if (cb_reg < CW'(MAX_TERMS))
                            begin
                                wr_b    = 1'b1;
                                cb_next = cb_reg + CW'(1);
                            end
                            else
                                ovf_next = 1'b1;
                        end
                        OP_COMPUTE:
                        begin
                            any_next = 1'b0;
                            top_next = '0;
                            k_next   = '0;
                            e_next   = '0;
                            if (ca_reg == '0 || cb_reg == '0)
                                state_next = S_EMIT_RD;
                            else
                                state_next = S_BOUND;
                        end
                        default:
                            cmd_ready = 1'b1;
                    endcase
                end
            end
            S_BOUND:
            begin
                i_next     = lo;
                hi_next    = hi_full[AW-1:0];
                acc_next   = '0;
                state_next = S_RD;
            end
            S_RD:
                state_next = S_MUL;
            S_MUL:
                state_next = S_ACC;
            S_ACC:
            begin
                acc_next = acc_reg + PROD_W'(prod_reg);
                if (i_reg == hi_reg)
                    state_next = S_STORE;
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = S_RD;
                end
            end
            S_STORE:
            begin
                wr_w = 1'b1;
                if (acc_reg != '0)
                begin
                    any_next = 1'b1;
                    top_next = k_reg;
                end
                if ({1'b0, k_reg} == k_end)
                    state_next = S_EMIT_RD;
                else
                begin
                    k_next     = k_reg + DEG_W'(1);
                    state_next = S_BOUND;
                end
            end
            S_EMIT_RD:
                state_next = S_EMIT_OUT;
            S_EMIT_OUT:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (out_last_next)
                    begin
                        cmd_ready  = 1'b1;
                        ca_next    = '0;
                        cb_next    = '0;
                        ovf_next   = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        e_next     = e_reg + DEG_W'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ca_reg        <= '0;
            cb_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ca_reg        <= ca_next;
            cb_reg        <= cb_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        top_reg  <= top_next;
        e_reg    <= e_next;
        any_reg  <= any_next;
        i_reg    <= i_next;
        hi_reg   <= hi_next;
        acc_reg  <= acc_next;
        prod_reg <= a_rd_reg * b_rd_reg;
        if (out_load)
        begin
            out_coef_reg <= any_reg ? w_rd_reg : '0;
            out_deg_reg  <= e_reg;
            out_ovf_reg  <= ovf_reg;
            out_last_reg <= out_last_next;
        end
    end

    // Coefficient and work memories with registered reads
    always_ff @(posedge clk)
    begin
        if (wr_a)
            a_mem[ca_reg[AW-1:0]] <= cmd.coef[COEF_BITS-1:0];
        if (wr_b)
            b_mem[cb_reg[AW-1:0]] <= cmd.coef[COEF_BITS-1:0];
        if (wr_w)
            w_mem[k_reg] <= acc_reg;
        a_rd_reg <= a_mem[i_reg];
        b_rd_reg <= b_mem[b_addr];
        w_rd_reg <= w_mem[e_reg];
    end

    assign empty        = !out_valid_reg;
    assign product_coef = out_coef_reg;
    assign degree_index = out_deg_reg;
    assign overflow     = out_ovf_reg;
    assign last         = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ca_reg <= CW'(MAX_TERMS) && cb_reg <= CW'(MAX_TERMS))
        else $error("coefficient count beyond capacity");

    a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |-> i_reg <= hi_reg)
        else $error("term index past upper bound");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_OUT && out_load && out_last_next) |=> state_reg == S_IDLE)
        else $error("emit pass did not finish after last item");

endmodule

FILE: src/poly_multiply_fft.sv
// Top level of the polynomial multiplier.
// A compute walks every coefficient pair through one multiply-accumulate unit,
// pair by pair and product degree by degree, then emits the product coefficients
// one at a time (held while pop stalls). The product is the exact integer
// convolution, lowest degree first.
module poly_multiply_fft import pmf_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEF,
    parameter int COEF_BITS = COEF_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [1:0]                     opcode,
    input  logic signed [COEF_FIELD_W-1:0] coef_value,
    output logic                           empty,
    input  logic                           pop,
    output logic signed [PROD_W-1:0]       product_coef,
    output logic [DEG_W-1:0]               degree_index,
    output logic                           overflow,
    output logic                           last
);

    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    pmf_front #(.COEF_BITS(COEF_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .coef_value (coef_value),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_ready  (cmd_ready)
    );

    pmf_back #(.MAX_TERMS(MAX_TERMS), .COEF_BITS(COEF_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_ready    (cmd_ready),
        .empty        (empty),
        .pop          (pop),
        .product_coef (product_coef),
        .degree_index (degree_index),
        .overflow     (overflow),
        .last         (last)
    );

endmodule

FILE: tb/sv/tb_poly_multiply_fft.sv
// Testbench for the polynomial multiplier: random load/compute sequences checked against a convolution predictor.
module tb_poly_multiply_fft;
    import pmf_pkg::*;

    localparam int TERMS = MAX_TERMS_DEF;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        op_t               op;
        logic signed [15:0] coef;
    } load_item_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] coef;
        logic [DEG_W-1:0]         deg;
        logic                     ovf;
        logic                     last;
    } prod_term_t;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    logic [1:0] opcode;
    logic signed [COEF_FIELD_W-1:0] coef_value;
    logic empty;
    logic pop;
    logic signed [PROD_W-1:0] product_coef;
    logic [DEG_W-1:0] degree_index;
    logic overflow;
    logic last;

    load_item_t pending_items[$];
    prod_term_t expected_terms[$];

    // Predictor state
    logic signed [15:0] poly_a[TERMS];
    logic signed [15:0] poly_b[TERMS];
    int count_a;
    int count_b;
    bit dropped_seen;

    int sender_idle_pct;
    int receiver_stall_pct;
    int fail_count;
    longint cycle_count;

    poly_multiply_fft i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .opcode(opcode), .coef_value(coef_value), .empty(empty), .pop(pop),
        .product_coef(product_coef), .degree_index(degree_index),
        .overflow(overflow), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Predict the product terms for one accepted item
    task automatic predict_convolution(load_item_t it);
        longint sums[WORK_DEPTH];
        int top;
        int n;
        prod_term_t t;
        foreach (sums[k]) sums[k] = 0;
        case (it.op)
            OP_LOAD_A:
            begin
                if (count_a < TERMS) begin poly_a[count_a] = it.coef; count_a++; end
                else dropped_seen = 1'b1;
            end
            OP_LOAD_B:
            begin
                if (count_b < TERMS) begin poly_b[count_b] = it.coef; count_b++; end
                else dropped_seen = 1'b1;
            end
            OP_COMPUTE:
            begin
                for (int i = 0; i < count_a; i++)
                    for (int j = 0; j < count_b; j++)
                        sums[(i + j) % WORK_DEPTH] += longint'(poly_a[i]) * longint'(poly_b[j]);
                top = -1;
                for (int k = 0; k < WORK_DEPTH; k++)
                    if (sums[k] != 0) top = k;
                n = (top < 0) ? 1 : top + 1;
                for (int k = 0; k < n; k++)
                begin
                    t.coef = sums[k][PROD_W-1:0];
                    t.deg = k[DEG_W-1:0];
                    t.ovf = dropped_seen;
                    t.last = (k == n - 1);
                    expected_terms.push_back(t);
                end
                count_a = 0;
                count_b = 0;
                dropped_seen = 1'b0;
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 7)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_poly_job(int na, int nb);
        load_item_t it;
        // interleave loads of both operands in random order
        while (na > 0 || nb > 0)
        begin
            if (na > 0 && (nb == 0 || $urandom_range(0, 1)))
            begin
                it.op = OP_LOAD_A; na--;
            end
            else
            begin
                it.op = OP_LOAD_B; nb--;
            end
            it.coef = rand_coef();
            pending_items.push_back(it);
        end
        it.op = OP_COMPUTE;
        it.coef = 16'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic add_item(op_t op, logic signed [15:0] c);
        load_item_t it;
        it.op = op;
        it.coef = c;
        pending_items.push_back(it);
    endtask

    function automatic int pick_size();
        if ($urandom_range(0, 19) == 0) return $urandom_range(TERMS - 2, TERMS + 2);
        return $urandom_range(0, 5);
    endfunction

    // Driver: hold push until the item is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            opcode <= OP_LOAD_A;
            coef_value <= '0;
        end
        else
        begin
            if (push && !full)
                predict_convolution(load_item_t'({op_t'(opcode), coef_value}));
            if (!(push && full))
            begin
                if (pending_items.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    load_item_t it;
                    it = pending_items.pop_front();
                    push <= 1'b1;
                    opcode <= it.op;
                    coef_value <= it.coef;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: compare each popped term with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (expected_terms.size() == 0)
                begin
                    $error("unexpected product term, product_coef %0d", product_coef);
                    fail_count++;
                end
                else
                begin
                    prod_term_t e;
                    e = expected_terms.pop_front();
                    if (product_coef !== e.coef)
                    begin
                        $error("product_coef expected %0d actual %0d", e.coef, product_coef);
                        fail_count++;
                    end
                    if (degree_index !== e.deg)
                    begin
                        $error("degree_index expected %0d actual %0d", e.deg, degree_index);
                        fail_count++;
                    end
                    if (overflow !== e.ovf)
                    begin
                        $error("overflow expected %0d actual %0d", e.ovf, overflow);
                        fail_count++;
                    end
                    if (last !== e.last)
                    begin
                        $error("last expected %0d actual %0d", e.last, last);
                        fail_count++;
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** poly_multiply_fft: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int idle_set[4][2];
        int total;
        idle_set = '{'{0, 0}, '{54, 0}, '{0, 54}, '{26, 26}};
        rst_n = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        fail_count = 0;
        cycle_count = 0;
        count_a = 0;
        count_b = 0;
        dropped_seen = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty product, extremes, zero product, unused opcode, overflow
        add_item(OP_COMPUTE, 16'sh1234);
        add_item(OP_LOAD_A, 16'sh7fff);
        add_item(OP_LOAD_A, 16'sh8000);
        add_item(OP_LOAD_B, 16'sh8000);
        add_item(OP_LOAD_B, 16'sh7fff);
        add_item(OP_NONE, 16'sh5555);
        add_item(OP_COMPUTE, 16'shaaaa);
        add_item(OP_LOAD_A, 16'sh0000);
        add_item(OP_LOAD_B, 16'sh0003);
        add_item(OP_COMPUTE, 16'sh0000);
        add_item(OP_LOAD_A, 16'sh0001);
        add_item(OP_LOAD_A, 16'sh0000);
        add_item(OP_LOAD_B, 16'shffff);
        add_item(OP_LOAD_B, 16'sh0000);
        add_item(OP_COMPUTE, 16'shffff);
        for (int k = 0; k < TERMS + 1; k++) add_item(OP_LOAD_A, 16'sh8000);
        for (int k = 0; k < TERMS + 1; k++) add_item(OP_LOAD_B, 16'sh8000);
        add_item(OP_COMPUTE, 16'sh0000);

        // Random jobs across the idling phases
        total = pending_items.size();
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = idle_set[p][0];
            receiver_stall_pct = idle_set[p][1];
            for (int q = 0; q < 87 && total < 430; )
            begin
                int before_n;
                before_n = pending_items.size();
                if ($urandom_range(0, 9) == 0)
                    add_item(op_t'($urandom_range(0, 3)), rand_coef());
                else
                    add_poly_job(pick_size(), pick_size());
                q += pending_items.size() - before_n;
                total += pending_items.size() - before_n;
            end
            wait (pending_items.size() == 0);
        end
        sender_idle_pct = 0;
        wait (expected_terms.size() == 0);
        repeat (4000) @(posedge clk);
        if (fail_count == 0 && expected_terms.size() == 0)
            $display("** poly_multiply_fft: PASSED **");
        else
            $display("** poly_multiply_fft: FAILED **");
        $finish;
    end

endmodule
